@@ hdl/usb_midi_descriptor_parser_assert.svh @@
// Assertion macros for the descriptor parser.
// UMDP_ASSERT checks a same-cycle implication, UMDP_ASSERT_NEXT one in the next cycle.
`ifndef USB_MIDI_DESCRIPTOR_PARSER_ASSERT_SVH
`define USB_MIDI_DESCRIPTOR_PARSER_ASSERT_SVH

`ifndef SYNTH
`define UMDP_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("umdp assertion failed");
`define UMDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("umdp assertion failed");
`else
`define UMDP_ASSERT(label, clk, rst, ante, cons)
`define UMDP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/umdp_pkg.sv @@
package umdp_pkg;

  localparam logic [7:0]  KindInterface = 8'h04;
  localparam logic [7:0]  KindEndpoint  = 8'h05;
  localparam logic [7:0]  XferMask      = 8'h03;
  localparam logic [7:0]  XferBulk      = 8'h02;
  localparam logic [7:0]  DirIn         = 8'h80;
  localparam logic [15:0] MpsDefault    = 16'd64;

  localparam logic [7:0]  MinLength     = 8'd2;
  localparam logic [7:0]  IfaceMinLen   = 8'd9;
  localparam logic [7:0]  EpMinLen      = 8'd7;

  // byte positions inside a descriptor
  localparam logic [7:0]  OffLength     = 8'd0;
  localparam logic [7:0]  OffKind       = 8'd1;
  localparam logic [7:0]  OffNumber     = 8'd2;
  localparam logic [7:0]  OffEpAttr     = 8'd3;
  localparam logic [7:0]  OffEpMpsLow   = 8'd4;
  localparam logic [7:0]  OffIfClass    = 8'd5;
  localparam logic [7:0]  OffEpMpsHigh  = 8'd5;
  localparam logic [7:0]  OffIfSubclass = 8'd6;

  localparam logic        CfgWantedClass    = 1'b0;
  localparam logic        CfgWantedSubclass = 1'b1;
  localparam logic [7:0]  ClassReset        = 8'h01;
  localparam logic [7:0]  SubclassReset     = 8'h03;

  typedef struct packed {
    logic [7:0]  byte_offset;
    logic [7:0]  desc_length;
    logic [7:0]  desc_kind;
    logic        in_target;
    logic        halted;
    logic [7:0]  held_number;
    logic [7:0]  held_attr;
    logic [7:0]  held_low;
    logic [7:0]  cap_iface;
    logic [7:0]  cap_out;
    logic [7:0]  cap_in;
    logic [15:0] cap_mps;
    logic        seen_out;
    logic        seen_in;
  } walk_t;

  localparam walk_t WalkClear = '{
    byte_offset: 8'd0, desc_length: 8'd0, desc_kind: 8'd0,
    in_target: 1'b0, halted: 1'b0,
    held_number: 8'd0, held_attr: 8'd0, held_low: 8'd0,
    cap_iface: 8'd0, cap_out: 8'd0, cap_in: 8'd0, cap_mps: MpsDefault,
    seen_out: 1'b0, seen_in: 1'b0
  };

  typedef struct packed {
    logic        found;
    logic [7:0]  iface_number;
    logic [7:0]  out_endpoint;
    logic [7:0]  in_endpoint;
    logic [15:0] in_max_packet;
  } result_t;

endpackage

@@ hdl/umdp_in_if.sv @@
interface umdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

@@ hdl/umdp_out_if.sv @@
interface umdp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  iface_number;
  logic [7:0]  out_endpoint;
  logic [7:0]  in_endpoint;
  logic [15:0] in_max_packet;

  modport source (output valid, output found, output iface_number, output out_endpoint,
                  output in_endpoint, output in_max_packet, input ready);
  modport sink (input valid, input found, input iface_number, input out_endpoint,
                input in_endpoint, input in_max_packet, output ready);
endinterface

@@ hdl/umdp_step.sv @@
module umdp_step (
  input  umdp_pkg::walk_t   walk,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  input  logic [7:0]        wanted_class,
  input  logic [7:0]        wanted_subclass,
  output umdp_pkg::walk_t   walk_next,
  output umdp_pkg::result_t res
);
  import umdp_pkg::*;

  walk_t      cur;
  walk_t      nx;
  logic [7:0] off;
  logic [7:0] len;
  logic [8:0] off_inc;
  logic       is_iface;
  logic       is_ep;

  always_comb begin
    cur      = first_byte ? WalkClear : walk;
    nx       = cur;
    off      = cur.byte_offset;
    len      = (off == OffLength) ? data_byte : cur.desc_length;
    off_inc  = {1'b0, off} + 9'd1;
    is_iface = (cur.desc_kind == KindInterface) && (cur.desc_length >= IfaceMinLen);
    is_ep    = (cur.desc_kind == KindEndpoint) && (cur.desc_length >= EpMinLen) &&
               cur.in_target;

    if (!cur.halted) begin
      if ((off == OffLength) && (data_byte < MinLength)) begin
        // too short to walk on: stop until the next block
        nx.halted = 1'b1;
      end else begin
        // bytes of other kinds, or at positions nobody needs, just move the offset
        if (off == OffLength) begin
          nx.desc_length = data_byte;
        end else if (off == OffKind) begin
          nx.desc_kind = data_byte;
        end else if (is_iface) begin
          if (off == OffNumber) begin
            nx.held_number = data_byte;
          end else if (off == OffIfClass) begin
            nx.held_attr = data_byte;
          end else if (off == OffIfSubclass) begin
            nx.in_target = (cur.held_attr == wanted_class) && (data_byte == wanted_subclass);
            if ((cur.held_attr == wanted_class) && (data_byte == wanted_subclass)) begin
              nx.cap_iface = cur.held_number;
            end
          end
        end else if (is_ep) begin
          if (off == OffNumber) begin
            nx.held_number = data_byte;
          end else if (off == OffEpAttr) begin
            nx.held_attr = data_byte;
          end else if (off == OffEpMpsLow) begin
            nx.held_low = data_byte;
          end else if ((off == OffEpMpsHigh) && ((cur.held_attr & XferMask) == XferBulk)) begin
            if ((cur.held_number & DirIn) != 8'd0) begin
              nx.cap_in  = cur.held_number;
              nx.cap_mps = ({data_byte, cur.held_low} == 16'd0) ? MpsDefault
                                                                : {data_byte, cur.held_low};
              nx.seen_in = 1'b1;
            end else begin
              nx.cap_out  = cur.held_number;
              nx.seen_out = 1'b1;
            end
          end
        end
        nx.byte_offset = (off_inc >= {1'b0, len}) ? 8'd0 : off_inc[7:0];
      end
    end

    // captures stay; the walk stops after the block's final byte
    if (last_byte) begin
      nx.halted = 1'b1;
    end

    walk_next         = nx;
    res.found         = nx.seen_out && nx.seen_in;
    res.iface_number  = nx.cap_iface;
    res.out_endpoint  = nx.cap_out;
    res.in_endpoint   = nx.cap_in;
    res.in_max_packet = nx.cap_mps;
  end

endmodule

@@ hdl/usb_midi_descriptor_parser.sv @@
// A result appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; the next byte is taken while a result
// waits, as long as the result register is free or being emptied.
// Reset (rst, synchronous, active high) clears the walk and captures,
// sets wanted class 1 and subclass 3, and empties the result register.
module usb_midi_descriptor_parser (
  input  logic        clk,
  input  logic        rst,
  umdp_in_if.sink     desc,
  umdp_out_if.source  result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import umdp_pkg::*;

  `include "usb_midi_descriptor_parser_assert.svh"

  walk_t      walk;
  walk_t      walk_next;
  result_t    res_next;
  result_t    res;
  logic       res_valid;
  logic [7:0] wanted_class;
  logic [7:0] wanted_subclass;
  logic       in_fire;

  assign desc.ready = !res_valid || result.ready;
  assign in_fire    = desc.valid && desc.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_class    <= ClassReset;
      wanted_subclass <= SubclassReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgWantedClass:    wanted_class    <= cfg_data;
        CfgWantedSubclass: wanted_subclass <= cfg_data;
        default:           wanted_class    <= wanted_class;
      endcase
    end
  end

  umdp_step u_step (
    .walk            (walk),
    .data_byte       (desc.data_byte),
    .first_byte      (desc.first_byte),
    .last_byte       (desc.last_byte),
    .wanted_class    (wanted_class),
    .wanted_subclass (wanted_subclass),
    .walk_next       (walk_next),
    .res             (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= WalkClear;
    end else if (in_fire) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= desc.last_byte;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && desc.last_byte) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.found         = res.found;
  assign result.iface_number  = res.iface_number;
  assign result.out_endpoint  = res.out_endpoint;
  assign result.in_endpoint   = res.in_endpoint;
  assign result.in_max_packet = res.in_max_packet;

  `UMDP_ASSERT_NEXT(a_last_gives_result, clk, rst, in_fire && desc.last_byte, res_valid)
  `UMDP_ASSERT_NEXT(a_last_halts, clk, rst, in_fire && desc.last_byte, walk.halted)
  `UMDP_ASSERT(a_found_has_in, clk, rst, res_valid && res.found, res.in_endpoint[7])
  `UMDP_ASSERT(a_mps_default, clk, rst, !walk.seen_in, walk.cap_mps == MpsDefault)
  `UMDP_ASSERT(a_offset_in_desc, clk, rst, walk.byte_offset != 8'd0,
    walk.byte_offset < walk.desc_length)

endmodule
